### hw/rtl/ilc_pkg.sv
package ilc_pkg;

    localparam int MAX_STEPS  = 256;
    localparam int ADDR_W     = $clog2(MAX_STEPS);
    localparam int STEP_W     = ADDR_W + 1;
    localparam int SIG_W      = 16;
    localparam int SUM_W      = SIG_W + 8;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int FRAC_BITS  = 12;
    localparam int ACC_W      = 43;
    localparam int CNT_W      = 16;
    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [GAIN_W-1:0] FORGET_RST = GAIN_W'(4096);
    localparam logic [STEP_W-1:0]        STEPS_RST  = STEP_W'(MAX_STEPS);
    localparam logic [LIM_W-1:0]         LIMIT_RST  = LIM_W'(100);

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_RECORD = 2'd1,
        OP_START  = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LAW_P   = 2'd0,
        LAW_D   = 2'd1,
        LAW_PD  = 2'd2,
        LAW_PID = 2'd3
    } t_law;

    typedef enum logic [2:0] {
        REG_LAW    = 3'd0,
        REG_GAIN_P = 3'd1,
        REG_GAIN_I = 3'd2,
        REG_GAIN_D = 3'd3,
        REG_FORGET = 3'd4,
        REG_STEPS  = 3'd5,
        REG_LIMIT  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2,
        ST_SWEEP = 2'd3
    } t_state;

    typedef struct packed {
        t_law                      law;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [GAIN_W-1:0]  forget;
        logic [STEP_W-1:0]         steps;
        logic [LIM_W-1:0]          limit;
    } t_cfg;

    typedef struct packed {
        logic signed [SIG_W-1:0] control;
        logic                    step_valid;
        logic [CNT_W-1:0]        trial_count;
    } t_rsp;

endpackage

### hw/rtl/ilc_if.sv
interface ilc_req_if import ilc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic signed [STEP_W-1:0] step_index;
    logic signed [SIG_W-1:0] reference;
    logic signed [SIG_W-1:0] measurement;
    logic signed [SIG_W-1:0] error_value;

    modport source (
        output valid, opcode, step_index, reference, measurement, error_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, step_index, reference, measurement, error_value,
        output ready
    );
endinterface

interface ilc_rsp_if import ilc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SIG_W-1:0] control;
    logic                    step_valid;
    logic [CNT_W-1:0]        trial_count;

    modport source (
        output valid, control, step_valid, trial_count,
        input  ready
    );
    modport sink (
        input  valid, control, step_valid, trial_count,
        output ready
    );
endinterface

### hw/rtl/ilc_ram.sv
module ilc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/ilc_cfg.sv
module ilc_cfg import ilc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(i_paddr[CFG_AW-1:2]);
    assign wr_en   = i_psel && i_penable && i_pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.law    <= LAW_P;
            r_cfg.gain_p <= '0;
            r_cfg.gain_i <= '0;
            r_cfg.gain_d <= '0;
            r_cfg.forget <= FORGET_RST;
            r_cfg.steps  <= STEPS_RST;
            r_cfg.limit  <= LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LAW:    r_cfg.law    <= t_law'(i_pwdata[1:0]);
                REG_GAIN_P: r_cfg.gain_p <= i_pwdata[GAIN_W-1:0];
                REG_GAIN_I: r_cfg.gain_i <= i_pwdata[GAIN_W-1:0];
                REG_GAIN_D: r_cfg.gain_d <= i_pwdata[GAIN_W-1:0];
                REG_FORGET: r_cfg.forget <= i_pwdata[GAIN_W-1:0];
                REG_STEPS:  r_cfg.steps  <= i_pwdata[STEP_W-1:0];
                REG_LIMIT:  r_cfg.limit  <= i_pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LAW:    o_prdata = CFG_DW'(r_cfg.law);
            REG_GAIN_P: o_prdata = CFG_DW'($unsigned(r_cfg.gain_p));
            REG_GAIN_I: o_prdata = CFG_DW'($unsigned(r_cfg.gain_i));
            REG_GAIN_D: o_prdata = CFG_DW'($unsigned(r_cfg.gain_d));
            REG_FORGET: o_prdata = CFG_DW'($unsigned(r_cfg.forget));
            REG_STEPS:  o_prdata = CFG_DW'(r_cfg.steps);
            REG_LIMIT:  o_prdata = CFG_DW'(r_cfg.limit);
            default:    o_prdata = '0;
        endcase
    end

endmodule

### hw/rtl/iterative_learning_controller.sv
// Iterative learning controller, one request per opcode on i_req, one response
// per request on o_rsp, in request order. Registers sit on the APB port.
// Update, record error and start trial (outside the PID law) are taken one per
// cycle while i_req.ready is high: in the run state, outside the copy write and
// with room left in the response queue. A request passes the pipeline (read of
// the per-step memories, products, sum, shift and saturate) and is then pushed
// into the response queue, where it raises o_rsp.valid.
// End trial, and start trial under the PID law, close the request port while
// the pipeline drains and then sweep the per-step memories, one step per cycle
// for the number of steps in use: start trial clears the error sums, end trial
// copies current control into previous control from a registered read of the
// current-control memory. Rate is set by the single write port of each memory.
// After reset the block clears all 256 steps of every per-step memory, one step
// per cycle; i_req.ready stays low meanwhile. Register writes work at once.
// An 8-entry response queue decouples the sides: when the receiver stalls,
// requests keep being taken until the queue plus the items in flight fill it.
module iterative_learning_controller import ilc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ilc_req_if.sink           i_req,
    ilc_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    ilc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    assign pready = 1'b1;

    // request decode
    logic [STEP_W-1:0] act_n;
    logic [ADDR_W-1:0] req_addr;
    logic              req_ok;
    logic              in_acc;
    logic              sweep_op;

    assign act_n = (cfg.steps == '0 || cfg.steps > STEP_W'(MAX_STEPS)) ?
                   STEP_W'(MAX_STEPS) : cfg.steps;
    assign req_addr = i_req.step_index[ADDR_W-1:0];
    assign req_ok   = !i_req.step_index[STEP_W-1] && ({1'b0, req_addr} < act_n);
    assign in_acc   = i_req.valid && i_req.ready;
    assign sweep_op = (i_req.opcode == OP_END) ||
                      (i_req.opcode == OP_START && cfg.law == LAW_PID);

    // control FSM
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_copy;
    logic              r_cp_v;
    logic [ADDR_W-1:0] r_cp_addr;
    logic              r_v1, r_v2, r_v3;
    logic              clr_all, clr_sum, cp_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        clr_all = 1'b0;
        clr_sum = 1'b0;
        cp_rd   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_all = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == ADDR_W'(MAX_STEPS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (in_acc && sweep_op) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_idx = '0;
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                clr_sum = !r_copy;
                cp_rd   = r_copy;
                n_idx   = r_idx + 1'b1;
                if ({1'b0, r_idx} == act_n - 1'b1) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // response queue and credit
    t_rsp               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW+1:0] occ;
    logic               push, pop;
    t_rsp               rsp3;

    assign occ = (FIFO_AW+2)'(r_cnt) + (FIFO_AW+2)'(r_v1) + (FIFO_AW+2)'(r_v2)
               + (FIFO_AW+2)'(r_v3);
    assign i_req.ready = (r_state == ST_RUN) && !r_cp_v && (occ < FIFO_DEPTH);

    assign push = r_v3;
    assign pop  = o_rsp.valid && o_rsp.ready;

    assign o_rsp.valid       = (r_cnt != '0);
    assign o_rsp.control     = r_fifo[r_rp].control;
    assign o_rsp.step_valid  = r_fifo[r_rp].step_valid;
    assign o_rsp.trial_count = r_fifo[r_rp].trial_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= rsp3;
        end
    end

    // trial counter
    logic [CNT_W-1:0] r_trials;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trials <= '0;
        end else if (in_acc && i_req.opcode == OP_END && r_trials != '1) begin
            r_trials <= r_trials + 1'b1;
        end
    end

    // per-step memories
    logic signed [SIG_W-1:0] err_rd_a, err_rd_b, prev_rd, cur_rd;
    logic [SUM_W-1:0]        sum_rd_raw;
    logic                    err_we, sum_we, cur_we, prev_we;
    logic [ADDR_W-1:0]       err_waddr, sum_waddr, cur_waddr, prev_waddr;
    logic [SIG_W-1:0]        err_wdata, cur_wdata, prev_wdata;
    logic [SUM_W-1:0]        sum_wdata;
    logic                    sum_we1;
    logic signed [SUM_W-1:0] sum_new;
    logic [ADDR_W-1:0]       r_addr1, r_addr3;
    logic                    r_upd3;
    logic signed [SIG_W-1:0] ctl;

    assign err_we    = clr_all || (in_acc && i_req.opcode == OP_RECORD && req_ok);
    assign err_waddr = clr_all ? r_idx : req_addr;
    assign err_wdata = clr_all ? '0 : i_req.error_value;

    assign sum_we    = clr_all || clr_sum || sum_we1;
    assign sum_waddr = (clr_all || clr_sum) ? r_idx : r_addr1;
    assign sum_wdata = (clr_all || clr_sum) ? '0 : sum_new;

    assign cur_we    = clr_all || r_upd3;
    assign cur_waddr = clr_all ? r_idx : r_addr3;
    assign cur_wdata = clr_all ? '0 : ctl;

    assign prev_we    = clr_all || r_cp_v;
    assign prev_waddr = clr_all ? r_idx : r_cp_addr;
    assign prev_wdata = clr_all ? '0 : cur_rd;

    ilc_ram #(.WIDTH(SIG_W), .DEPTH(MAX_STEPS)) u_err_a (
        .i_clk (i_clk), .i_we (err_we), .i_waddr (err_waddr), .i_wdata (err_wdata),
        .i_raddr (req_addr), .o_rdata (err_rd_a)
    );

    ilc_ram #(.WIDTH(SIG_W), .DEPTH(MAX_STEPS)) u_err_b (
        .i_clk (i_clk), .i_we (err_we), .i_waddr (err_waddr), .i_wdata (err_wdata),
        .i_raddr (req_addr - 1'b1), .o_rdata (err_rd_b)
    );

    ilc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_STEPS)) u_sum (
        .i_clk (i_clk), .i_we (sum_we), .i_waddr (sum_waddr), .i_wdata (sum_wdata),
        .i_raddr (req_addr), .o_rdata (sum_rd_raw)
    );

    ilc_ram #(.WIDTH(SIG_W), .DEPTH(MAX_STEPS)) u_prev (
        .i_clk (i_clk), .i_we (prev_we), .i_waddr (prev_waddr), .i_wdata (prev_wdata),
        .i_raddr (req_addr), .o_rdata (prev_rd)
    );

    ilc_ram #(.WIDTH(SIG_W), .DEPTH(MAX_STEPS)) u_cur (
        .i_clk (i_clk), .i_we (cur_we), .i_waddr (cur_waddr), .i_wdata (cur_wdata),
        .i_raddr (r_idx), .o_rdata (cur_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_v <= 1'b0;
            r_copy <= 1'b0;
        end else begin
            r_cp_v <= cp_rd;
            if (in_acc && sweep_op) begin
                r_copy <= (i_req.opcode == OP_END);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_idx;
    end

    // stage 1: memory data, error sum, products
    t_op                     r_op1;
    logic                    r_ok1;
    logic signed [SIG_W:0]   r_e1;
    logic                    r_sw_v;
    logic [ADDR_W-1:0]       r_sw_addr;
    logic signed [SUM_W-1:0] r_sw_data;
    logic                    upd1, first1;
    logic signed [SUM_W-1:0] sum_rd;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [SIG_W:0]   de, pa;
    logic signed [GAIN_W+SIG_W:0]   pp, pd;
    logic signed [GAIN_W+SIG_W-1:0] pq;
    logic signed [GAIN_W+SUM_W-1:0] pi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1   <= t_op'(i_req.opcode);
        r_ok1   <= req_ok;
        r_addr1 <= req_addr;
        r_e1    <= i_req.reference - i_req.measurement;
    end

    assign upd1    = r_v1 && (r_op1 == OP_UPDATE) && r_ok1;
    assign first1  = (r_trials == '0);
    assign sum_we1 = upd1 && !first1 && (cfg.law == LAW_PID);

    always_comb begin
        if (r_sw_v && r_sw_addr == r_addr1) begin
            sum_rd = r_sw_data;
        end else begin
            sum_rd = sum_rd_raw;
        end
        sum_ext = sum_rd + err_rd_a;
        if (sum_ext > SUM_MAX) begin
            sum_new = SUM_MAX;
        end else if (sum_ext < SUM_MIN) begin
            sum_new = SUM_MIN;
        end else begin
            sum_new = sum_ext[SUM_W-1:0];
        end

        if (r_addr1 == '0) begin
            de = '0;
        end else begin
            de = err_rd_a - err_rd_b;
        end
        if (first1) begin
            pa = r_e1;
        end else begin
            pa = err_rd_a;
        end

        pp = '0;
        pq = '0;
        pd = '0;
        pi = '0;
        if (first1 || cfg.law != LAW_D) begin
            pp = cfg.gain_p * pa;
        end
        if (!first1) begin
            pq = cfg.forget * prev_rd;
        end
        if (!first1 && cfg.law != LAW_P) begin
            pd = cfg.gain_d * de;
        end
        if (!first1 && cfg.law == LAW_PID) begin
            pi = cfg.gain_i * sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_v <= 1'b0;
        end else begin
            r_sw_v <= sum_we1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_addr <= r_addr1;
        r_sw_data <= sum_new;
    end

    // stage 2: accumulate
    logic signed [GAIN_W+SIG_W:0]   r_pp2, r_pd2;
    logic signed [GAIN_W+SIG_W-1:0] r_pq2;
    logic signed [GAIN_W+SUM_W-1:0] r_pi2;
    logic                           r_upd2, r_sv2;
    logic [ADDR_W-1:0]              r_addr2;
    logic [CNT_W-1:0]               r_tc2;
    logic signed [ACC_W-1:0]        n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp2   <= pp;
        r_pq2   <= pq;
        r_pd2   <= pd;
        r_pi2   <= pi;
        r_upd2  <= upd1;
        r_sv2   <= r_ok1 && (r_op1 == OP_UPDATE || r_op1 == OP_RECORD);
        r_addr2 <= r_addr1;
        r_tc2   <= r_trials;
    end

    assign n_acc = r_pp2 + r_pq2 + r_pd2 + r_pi2;

    // stage 3: shift, saturate, write back
    logic signed [ACC_W-1:0] r_acc3, sh;
    logic                    r_sv3;
    logic [CNT_W-1:0]        r_tc3;
    logic signed [SIG_W-1:0] lim_s, neg_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3   <= 1'b0;
            r_upd3 <= 1'b0;
        end else begin
            r_v3   <= r_v2;
            r_upd3 <= r_v2 && r_upd2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc3  <= n_acc;
        r_sv3   <= r_sv2;
        r_addr3 <= r_addr2;
        r_tc3   <= r_tc2;
    end

    assign sh      = r_acc3 >>> FRAC_BITS;
    assign lim_s   = {1'b0, cfg.limit};
    assign neg_lim = -lim_s;

    always_comb begin
        if (sh > lim_s) begin
            ctl = lim_s;
        end else if (sh < neg_lim) begin
            ctl = neg_lim;
        end else begin
            ctl = sh[SIG_W-1:0];
        end
        rsp3.control     = r_upd3 ? ctl : '0;
        rsp3.step_valid  = r_sv3;
        rsp3.trial_count = r_tc3;
    end

endmodule

### hw/rtl/ilc_checker.sv
module ilc_checker import ilc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic [1:0]              i_in_opcode,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SIG_W-1:0] i_out_control,
    input logic                    i_out_step_valid,
    input logic [CNT_W-1:0]        i_out_trial_count
);

    logic in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("request taken during memory clear");

    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_opcode == OP_END |=> !i_in_ready)
        else $error("request taken during trial sweep");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_step_valid |-> i_out_control == '0)
        else $error("nonzero control on invalid step");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc ##1 i_out_valid |-> i_out_trial_count >= $past(i_out_trial_count))
        else $error("trial count went backwards");

endmodule

bind iterative_learning_controller ilc_checker u_ilc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_in_opcode       (i_req.opcode),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_control     (o_rsp.control),
    .i_out_step_valid  (o_rsp.step_valid),
    .i_out_trial_count (o_rsp.trial_count)
);

### bench/tb_iterative_learning_controller.sv
module tb_iterative_learning_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ilc_pkg::*;

    localparam int    HALF_PERIOD   = 5;
    localparam int    SWEEP_SETTLE  = 300;
    localparam int    RANDOM_ITEMS  = 80;
    localparam int    TRIAL_BURST   = 20;
    localparam longint CYCLE_LIMIT  = 4_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilc_req_if req_if ();
    ilc_rsp_if rsp_if ();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    iterative_learning_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // controller register copy
    t_law               cfg_law     = LAW_P;
    logic signed [15:0] cfg_gain_p  = '0;
    logic signed [15:0] cfg_gain_i  = '0;
    logic signed [15:0] cfg_gain_d  = '0;
    logic signed [15:0] cfg_forget  = FORGET_RST;
    logic [8:0]         cfg_steps   = STEPS_RST;
    logic [14:0]        cfg_limit   = LIMIT_RST;

    // per-step stores and trial counter
    longint      prev_ctl_mem [MAX_STEPS];
    longint      cur_ctl_mem  [MAX_STEPS];
    longint      err_mem      [MAX_STEPS];
    longint      err_sum_mem  [MAX_STEPS];
    logic [15:0] trials_done = '0;

    t_rsp   pending_rsp [$];
    t_rsp   rsp_want;
    int     mismatch_count = 0;
    int     rsp_checked    = 0;
    int     req_sent       = 0;
    int     op_count [4]   = '{0, 0, 0, 0};
    int     cfg_writes     = 0;
    int     burst_left     = 0;
    bit     no_gaps        = 1'b0;
    bit     rx_always      = 1'b0;
    int     rx_mode        = 0;
    int     rx_mode_left   = 0;
    longint cycle_count    = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at response %0d",
                 what, got, want, rsp_checked);
    endtask

    function automatic t_rsp predict_control(input t_op op, input logic signed [8:0] step,
                                             input logic signed [15:0] ref_val,
                                             input logic signed [15:0] meas_val,
                                             input logic signed [15:0] err_val);
        longint acc;
        longint ep;
        longint de;
        longint ctl;
        longint lim;
        int     n;
        int     s;
        bit     ok;
        t_rsp   r;
        n   = (cfg_steps == 0 || cfg_steps > MAX_STEPS) ? MAX_STEPS : int'(cfg_steps);
        ok  = (step >= 0) && (int'(step) < n);
        s   = ok ? int'(step) : 0;
        ctl = 0;
        lim = longint'(cfg_limit);
        case (op)
            OP_UPDATE: begin
                if (ok) begin
                    if (trials_done == 0) begin
                        acc = longint'(cfg_gain_p) * (longint'(ref_val) - longint'(meas_val));
                    end else begin
                        ep  = err_mem[s];
                        de  = (s > 0) ? ep - err_mem[s-1] : 0;
                        acc = longint'(cfg_forget) * prev_ctl_mem[s];
                        case (cfg_law)
                            LAW_P:  acc += longint'(cfg_gain_p) * ep;
                            LAW_D:  acc += longint'(cfg_gain_d) * de;
                            LAW_PD: acc += longint'(cfg_gain_p) * ep + longint'(cfg_gain_d) * de;
                            default: begin
                                err_sum_mem[s] += ep;
                                if (err_sum_mem[s] > longint'(SUM_MAX)) begin
                                    err_sum_mem[s] = longint'(SUM_MAX);
                                end
                                if (err_sum_mem[s] < longint'(SUM_MIN)) begin
                                    err_sum_mem[s] = longint'(SUM_MIN);
                                end
                                acc += longint'(cfg_gain_p) * ep
                                     + longint'(cfg_gain_i) * err_sum_mem[s]
                                     + longint'(cfg_gain_d) * de;
                            end
                        endcase
                    end
                    ctl = acc >>> FRAC_BITS;
                    if (ctl > lim) ctl = lim;
                    if (ctl < -lim) ctl = -lim;
                    cur_ctl_mem[s] = ctl;
                end
            end
            OP_RECORD: begin
                if (ok) err_mem[s] = longint'(err_val);
            end
            OP_START: begin
                ok = 1'b0;
                if (cfg_law == LAW_PID) begin
                    for (int i = 0; i < n; i++) err_sum_mem[i] = 0;
                end
            end
            default: begin
                ok = 1'b0;
                for (int i = 0; i < n; i++) prev_ctl_mem[i] = cur_ctl_mem[i];
                if (trials_done != 16'hFFFF) trials_done++;
            end
        endcase
        r.control     = ctl[15:0];
        r.step_valid  = ok;
        r.trial_count = trials_done;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_sig16();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input t_op op, input logic signed [8:0] step,
                                input logic signed [15:0] ref_val,
                                input logic signed [15:0] meas_val,
                                input logic signed [15:0] err_val);
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.step_index  <= step;
        req_if.reference   <= ref_val;
        req_if.measurement <= meas_val;
        req_if.error_value <= err_val;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_rsp.push_back(predict_control(op, step, ref_val, meas_val, err_val));
        req_sent++;
        op_count[op]++;
        if (no_gaps || burst_left > 0) begin
            if (burst_left > 0) burst_left--;
        end else begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_random_noise();
        send_request(t_op'($urandom_range(0, 3)), 9'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    // hold the request side until every response is back, then let any sweep finish
    task automatic pause_until_drained(input int settle);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_LAW:    cfg_law    = t_law'(val[1:0]);
            REG_GAIN_P: cfg_gain_p = val[15:0];
            REG_GAIN_I: cfg_gain_i = val[15:0];
            REG_GAIN_D: cfg_gain_d = val[15:0];
            REG_FORGET: cfg_forget = val[15:0];
            REG_STEPS:  cfg_steps  = val[8:0];
            default:    cfg_limit  = val[14:0];
        endcase
        cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input t_law law, input logic signed [15:0] gp,
                              input logic signed [15:0] gi, input logic signed [15:0] gd,
                              input logic signed [15:0] fq, input logic [8:0] steps,
                              input logic [14:0] lim);
        apb_write(REG_LAW, 32'(law));
        apb_write(REG_GAIN_P, 32'(gp));
        apb_write(REG_GAIN_I, 32'(gi));
        apb_write(REG_GAIN_D, 32'(gd));
        apb_write(REG_FORGET, 32'(fq));
        apb_write(REG_STEPS, 32'(steps));
        apb_write(REG_LIMIT, 32'(lim));
    endtask

    // first trial: proportional feedback, range checks and store writes
    task automatic test_first_trial();
        set_config(LAW_P, 16'sh7FFF, '0, '0, 16'sd4096, 9'd256, 15'h7FFF);
        send_request(OP_UPDATE, 9'sd0, 16'sh7FFF, 16'sh8000, '0);
        send_request(OP_UPDATE, 9'sd255, 16'sh8000, 16'sh7FFF, '0);
        send_request(OP_UPDATE, 9'sd128, 16'sd300, -16'sd45, '0);
        send_request(OP_UPDATE, -9'sd1, 16'sd100, '0, '0);
        send_request(OP_UPDATE, -9'sd256, 16'sd100, '0, '0);
        send_request(OP_RECORD, 9'sd0, '0, '0, 16'sh7FFF);
        send_request(OP_RECORD, 9'sd1, '0, '0, 16'sh8000);
        send_request(OP_RECORD, -9'sd1, '0, '0, 16'sd5);
        send_request(OP_START, 9'sd0, '0, '0, '0);
        send_request(OP_END, 9'sd0, '0, '0, '0);
    endtask

    // later trials: each law at step zero and step one
    task automatic test_learning_laws();
        for (int l = 0; l < 4; l++) begin
            pause_until_drained(SWEEP_SETTLE);
            set_config(t_law'(l), 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                       9'd256, 15'h7FFF);
            send_request(OP_UPDATE, 9'sd0, '0, '0, '0);
            send_request(OP_UPDATE, 9'sd1, '0, '0, '0);
        end
        send_request(OP_START, 9'sd0, '0, '0, '0);
        send_request(OP_UPDATE, 9'sd1, '0, '0, '0);
    endtask

    // steps in use zero, above the store depth, small, and a zero output bound
    task automatic test_step_range();
        pause_until_drained(SWEEP_SETTLE);
        set_config(LAW_PD, 16'sd4096, '0, 16'sd4096, 16'sd4096, 9'd0, 15'd100);
        send_request(OP_UPDATE, 9'sd255, '0, '0, '0);
        pause_until_drained(SWEEP_SETTLE);
        apb_write(REG_STEPS, 32'd300);
        send_request(OP_UPDATE, 9'sd255, '0, '0, '0);
        pause_until_drained(SWEEP_SETTLE);
        apb_write(REG_STEPS, 32'd5);
        apb_write(REG_LIMIT, 32'd0);
        send_request(OP_UPDATE, 9'sd4, '0, '0, '0);
        send_request(OP_UPDATE, 9'sd5, '0, '0, '0);
        send_request(OP_RECORD, 9'sd5, '0, '0, 16'sd7);
    endtask

    // drive one error sum into its lower rail
    task automatic test_sum_saturation();
        pause_until_drained(SWEEP_SETTLE);
        set_config(LAW_PID, 16'sd16, 16'sd1, -16'sd16, 16'sd2048, 9'd1, 15'h7FFF);
        send_request(OP_START, 9'sd0, '0, '0, '0);
        send_request(OP_RECORD, 9'sd0, '0, '0, 16'sh8000);
        repeat (258) send_request(OP_UPDATE, 9'sd0, '0, '0, '0);
    endtask

    task automatic test_random_trials();
        int      start_count;
        int      n;
        int      walk;
        t_law    law;
        logic [8:0]  steps;
        logic [14:0] lim;
        start_count = req_sent;
        while (req_sent - start_count < RANDOM_ITEMS) begin
            pause_until_drained(SWEEP_SETTLE);
            law = t_law'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       steps = 9'd0;
                1:       steps = 9'd256;
                2:       steps = 9'($urandom_range(257, 511));
                default: steps = 9'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       lim = 15'd0;
                1:       lim = 15'h7FFF;
                default: lim = 15'($urandom_range(0, 32767));
            endcase
            set_config(law, rand_sig16(), rand_sig16(), rand_sig16(), rand_sig16(),
                       steps, lim);
            n    = (steps == 0 || steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
            walk = (n > 12) ? 12 : n;
            repeat ($urandom_range(1, 4)) begin
                send_request(OP_START, 9'($urandom), rand_sig16(), rand_sig16(), rand_sig16());
                for (int s = 0; s < walk; s++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        send_request(OP_RECORD, 9'(s), rand_sig16(), rand_sig16(),
                                     rand_sig16());
                    end
                    send_request(OP_UPDATE, 9'(s), rand_sig16(), rand_sig16(), rand_sig16());
                    if ($urandom_range(0, 9) == 0) send_random_noise();
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_request(OP_END, 9'($urandom), rand_sig16(), rand_sig16(),
                                 rand_sig16());
                end
            end
        end
    endtask

    // closing requests back to back, then the law on the new trial count
    task automatic test_trial_burst();
        pause_until_drained(SWEEP_SETTLE);
        set_config(LAW_PD, 16'sd4096, '0, 16'sd2048, 16'sd4096, 9'd1, 15'd1000);
        no_gaps   = 1'b1;
        rx_always = 1'b1;
        send_request(OP_RECORD, 9'sd0, '0, '0, 16'sd123);
        repeat (TRIAL_BURST) send_request(OP_END, 9'sd0, '0, '0, '0);
        no_gaps   = 1'b0;
        rx_always = 1'b0;
        send_request(OP_UPDATE, 9'sd0, 16'sd50, 16'sd10, '0);
        send_request(OP_END, 9'sd0, '0, '0, '0);
        send_request(OP_UPDATE, 9'sd0, 16'sd50, 16'sd10, '0);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 150);
        end else begin
            rx_mode_left--;
        end
        if (rx_always || rx_mode == 0) begin
            rsp_if.ready <= 1'b1;
        end else if (rx_mode == 1) begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
        end else begin
            rsp_if.ready <= ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with nothing pending", longint'(rsp_if.control), 0);
            end else begin
                rsp_want = pending_rsp.pop_front();
                if (rsp_if.control !== rsp_want.control) begin
                    report_mismatch("control", longint'(rsp_if.control),
                                    longint'(rsp_want.control));
                end
                if (rsp_if.step_valid !== rsp_want.step_valid) begin
                    report_mismatch("step_valid", longint'(rsp_if.step_valid),
                                    longint'(rsp_want.step_valid));
                end
                if (rsp_if.trial_count !== rsp_want.trial_count) begin
                    report_mismatch("trial_count", longint'(rsp_if.trial_count),
                                    longint'(rsp_want.trial_count));
                end
            end
            rsp_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, pending_rsp.size());
            $display("iterative_learning_controller verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_UPDATE;
        req_if.step_index  = '0;
        req_if.reference   = '0;
        req_if.measurement = '0;
        req_if.error_value = '0;
        rsp_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        foreach (prev_ctl_mem[i]) begin
            prev_ctl_mem[i] = 0;
            cur_ctl_mem[i]  = 0;
            err_mem[i]      = 0;
            err_sum_mem[i]  = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_trial();
        test_learning_laws();
        test_step_range();
        test_sum_saturation();
        test_random_trials();
        test_trial_burst();

        pause_until_drained(SWEEP_SETTLE);
        $display("ran %0d requests: %0d update, %0d record, %0d start, %0d end",
                 req_sent, op_count[OP_UPDATE], op_count[OP_RECORD],
                 op_count[OP_START], op_count[OP_END]);
        $display("checked %0d responses over %0d register writes, trial count %0d",
                 rsp_checked, cfg_writes, trials_done);
        if (mismatch_count == 0) begin
            $display("iterative_learning_controller verification clean");
        end else begin
            $display("iterative_learning_controller verification failed");
        end
        $finish;
    end

endmodule
